[rtl/biou_pkg.sv]
package biou_pkg;

   // register indexes on the configuration port
   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_Z = 3'd2;
   localparam logic [2:0] REG_SIZE_X   = 3'd3;
   localparam logic [2:0] REG_SIZE_Y   = 3'd4;
   localparam logic [2:0] REG_SIZE_Z   = 3'd5;

   localparam int NUM_AXES = 3;

endpackage

[rtl/box_iou_3d.sv]
// Channel | Ports          | Payload (low bit up)
// --------+----------------+--------------------------------------------------
// req     | req_t*         | cand_center_x/y/z, cand_size_x/y/z
// rsp     | rsp_t*         | tdata overlap_ratio, tuser empty_union
// csr     | csr_*          | index 0..5: ref center x/y/z, ref size x/y/z
//
// One request per cycle while the output is not stalled. Stages: bounds,
// overlap, two product stages, union, then one quotient bit per stage.
// Reset (synchronous, high) clears the valid bits and the csr registers to 0.
// The pipeline advances as a whole when the last stage is empty or taken,
// so a stall holds every stage and nothing is lost or repeated.
module box_iou_3d #(
   parameter int COORD_BITS      = 24,
   parameter int SIZE_BITS       = 16,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // cx,cy,cz at COORD_BITS each then sx,sy,sz at SIZE_BITS, zero padded
   input  logic [((3*COORD_BITS+3*SIZE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // overlap_ratio, zero padded
   output logic [((RATIO_FRAC_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // empty_union
   output logic rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int OW  = ((RATIO_FRAC_BITS+1+7)/8)*8;
   localparam int BW  = COORD_BITS + 2;          // doubled bound width, signed
   localparam int OVW = SIZE_BITS + 1;           // overlap width, at most 2*size
   localparam int PW  = 3*OVW;                   // I8 width
   localparam int VW  = 3*SIZE_BITS + 3;         // 8*v width
   localparam int UW  = ((PW > VW+1) ? PW : VW+1) + 1;
   localparam int QB  = RATIO_FRAC_BITS + 1;
   localparam int NST = 5 + QB;                  // stage count

   logic signed [COORD_BITS-1:0] rc_ff [3];
   logic [SIZE_BITS-1:0]         rs_ff [3];

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            rc_ff[a] <= '0;
            rs_ff[a] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            biou_pkg::REG_CENTER_X: rc_ff[0] <= csr_wdata[COORD_BITS-1:0];
            biou_pkg::REG_CENTER_Y: rc_ff[1] <= csr_wdata[COORD_BITS-1:0];
            biou_pkg::REG_CENTER_Z: rc_ff[2] <= csr_wdata[COORD_BITS-1:0];
            biou_pkg::REG_SIZE_X:   rs_ff[0] <= csr_wdata[SIZE_BITS-1:0];
            biou_pkg::REG_SIZE_Y:   rs_ff[1] <= csr_wdata[SIZE_BITS-1:0];
            biou_pkg::REG_SIZE_Z:   rs_ff[2] <= csr_wdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // global advance
   logic [NST-1:0] vld_ff;
   logic           adv;
   assign adv        = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NST-2:0], req_tvalid};
   end

   // stage 0: doubled bounds
   logic signed [BW-1:0] lo1_ff [3], hi1_ff [3], lo2_ff [3], hi2_ff [3];
   logic [SIZE_BITS-1:0] cs0_ff [3], rs0_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            logic signed [COORD_BITS-1:0] cc;
            logic signed [BW-1:0] c2, r2;
            cc = req_tdata[a*COORD_BITS +: COORD_BITS];
            c2 = BW'(cc) <<< 1;
            r2 = BW'(rc_ff[a]) <<< 1;
            cs0_ff[a] <= req_tdata[3*COORD_BITS + a*SIZE_BITS +: SIZE_BITS];
            rs0_ff[a] <= rs_ff[a];
            lo1_ff[a] <= r2 - $signed({2'b0, rs_ff[a]});
            hi1_ff[a] <= r2 + $signed({2'b0, rs_ff[a]});
            lo2_ff[a] <= c2 - $signed({2'b0,
               req_tdata[3*COORD_BITS + a*SIZE_BITS +: SIZE_BITS]});
            hi2_ff[a] <= c2 + $signed({2'b0,
               req_tdata[3*COORD_BITS + a*SIZE_BITS +: SIZE_BITS]});
         end
      end
   end

   // stage 1: clamped overlap, volumes' first product
   logic [OVW-1:0] ov_ff [3];
   logic [2*SIZE_BITS-1:0] v1a_ff, v2a_ff;
   logic [SIZE_BITS-1:0] rsz_ff, csz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            logic signed [BW-1:0] top, bot;
            top = (hi1_ff[a] < hi2_ff[a]) ? hi1_ff[a] : hi2_ff[a];
            bot = (lo1_ff[a] > lo2_ff[a]) ? lo1_ff[a] : lo2_ff[a];
            ov_ff[a] <= (top > bot) ? OVW'(top - bot) : '0;
         end
         v1a_ff <= rs0_ff[0] * rs0_ff[1];
         v2a_ff <= cs0_ff[0] * cs0_ff[1];
         rsz_ff <= rs0_ff[2];
         csz_ff <= cs0_ff[2];
      end
   end

   // stage 2: overlap xy, volumes done
   logic [2*OVW-1:0] oxy_ff;
   logic [OVW-1:0]   oz_ff;
   logic [VW-1:0]    v8_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         oxy_ff <= ov_ff[0] * ov_ff[1];
         oz_ff  <= ov_ff[2];
         v8_ff  <= (VW'(v1a_ff) * VW'(rsz_ff)) << 3;
      end
   end
   logic [VW-1:0] w8_ff;
   always_ff @(posedge clock) begin
      if (adv) w8_ff <= (VW'(v2a_ff) * VW'(csz_ff)) << 3;
   end

   // stage 3: intersection I8
   logic [PW-1:0] i8_ff;
   logic [VW:0]   vs_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         i8_ff <= oxy_ff * oz_ff;
         vs_ff <= {1'b0, v8_ff} + {1'b0, w8_ff};
      end
   end

   // stage 4: union
   logic [UW-1:0] rm_ff [QB+1];
   logic [UW-1:0] den_ff [QB+1];
   logic          emp_ff [QB+1];
   logic [QB-1:0] q_ff [QB+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         logic [UW-1:0] u;
         u = UW'(vs_ff) - UW'(i8_ff);
         den_ff[0] <= u;
         emp_ff[0] <= (u == '0);
         rm_ff[0]  <= UW'(i8_ff);
         q_ff[0]   <= '0;
      end
   end

   // quotient stages: first is the integer bit (rem >= U), then fractions
   genvar g;
   generate
      for (g = 0; g < QB; g++) begin : g_div
         logic [UW-1:0] r_n;
         logic          b_n;
         if (g == 0) begin : g_int
            assign b_n = rm_ff[0] >= den_ff[0];
            assign r_n = b_n ? rm_ff[0] - den_ff[0] : rm_ff[0];
         end else begin : g_frac
            biou_div_stage #(.W(UW)) u_step (
               .rem_i(rm_ff[g]), .den_i(den_ff[g]), .rem_o(r_n), .bit_o(b_n));
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               rm_ff[g+1]  <= r_n;
               den_ff[g+1] <= den_ff[g];
               emp_ff[g+1] <= emp_ff[g];
               q_ff[g+1]   <= {q_ff[g][QB-2:0], b_n};
            end
         end
      end
   endgenerate

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = emp_ff[QB] ? '0 : OW'(q_ff[QB]);
   assign rsp_tuser  = emp_ff[QB];

   property p_hold;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata) && rsp_tvalid;
   endproperty
   a_hold: assert property (p_hold) else $error("result changed under stall");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("empty union with nonzero ratio");

   a_ratio_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= OW'(1 << RATIO_FRAC_BITS)))
      else $error("ratio above one");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline blocked while output empty");
endmodule

[rtl/biou_div_stage.sv]
// One restoring-division step: shift remainder, compare, subtract.
module biou_div_stage #(
   parameter int W = 8
) (
   input  logic [W-1:0] rem_i,
   input  logic [W-1:0] den_i,
   output logic [W-1:0] rem_o,
   output logic         bit_o
);
   logic [W:0] shifted;
   logic [W:0] diff;

   always_comb begin
      shifted = {rem_i, 1'b0};
      diff    = shifted - {1'b0, den_i};
      bit_o   = !diff[W];
      rem_o   = bit_o ? diff[W-1:0] : shifted[W-1:0];
   end
endmodule
